[rtl/vclc_pkg.sv]
// Shared types, constants and lookup functions for the vehicle command and lamp controller.
package vclc_pkg;

  localparam int MELODY_NOTES_DEF = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_BLINK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_BEEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARK_DIM    = 3'd4;

  localparam logic [15:0] BRAKE_HOLD_RST  = 16'd1000;
  localparam logic [15:0] TURN_HALF_RST   = 16'd500;
  localparam logic [15:0] ALARM_BLINK_RST = 16'd350;
  localparam logic [15:0] ALARM_BEEP_RST  = 16'd700;
  localparam logic [7:0]  PARK_DIM_RST    = 8'd32;
  localparam logic [7:0]  SPEED_RST       = 8'd150;

  // motor direction pin codes
  localparam logic [1:0] DRV_OFF  = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_BACK = 2'd2;

  // lamp flag bit positions
  localparam int FL_HEAD   = 0;
  localparam int FL_PARK   = 1;
  localparam int FL_PMODE  = 2;
  localparam int FL_BRAKE  = 3;
  localparam int FL_HAZARD = 4;
  localparam int FL_REV    = 5;
  localparam int FL_LEFT   = 6;
  localparam int FL_RIGHT  = 7;

  localparam logic [15:0] BEEP_HZ    = 16'd1200;
  localparam logic [15:0] BEEP_MS    = 16'd120;
  localparam logic [9:0]  NOTE_GAP_MS = 10'd40;

  typedef struct packed {
    logic [15:0] brake_hold;
    logic [15:0] turn_half;
    logic [15:0] alarm_blink;
    logic [15:0] alarm_beep;
    logic [7:0]  park_dim;
  } cfg_t;

  typedef struct packed {
    logic [1:0] ldrv;
    logic [1:0] rdrv;
    logic [7:0] lpwm;
    logic [7:0] rpwm;
    logic [7:0] rear;
    logic       head;
    logic       front;
    logic       lturn;
    logic       rturn;
    logic       rev;
  } pins_t;

  typedef struct packed {
    logic [31:0] clock_ms;
    logic [31:0] brake_start;
    logic [31:0] blink_last;
    logic [31:0] alarm_last;
    logic [31:0] beep_last;
    logic [31:0] horn_start;
    logic [31:0] tone_start;
    logic [15:0] tone_freq;
    logic [15:0] tone_len;
    logic [7:0]  speed;
    logic [7:0]  flags;
    logic [2:0]  horn_idx;
    logic        enabled;
    logic        turn_phase;
    logic        alarm_on;
    logic        alarm_phase;
    logic        horn_playing;
    pins_t       pins;
  } state_t;

  function automatic logic [15:0] note_hz(input logic [2:0] idx);
    logic [15:0] hz;
    unique case (idx)
      3'd0:    hz = 16'd523;
      3'd1:    hz = 16'd392;
      3'd2:    hz = 16'd330;
      3'd3:    hz = 16'd262;
      3'd4:    hz = 16'd392;
      default: hz = 16'd523;
    endcase
    return hz;
  endfunction

  function automatic logic [8:0] note_ms(input logic [2:0] idx);
    logic [8:0] ms;
    unique case (idx)
      3'd0:    ms = 9'd160;
      3'd1:    ms = 9'd160;
      3'd2:    ms = 9'd200;
      3'd3:    ms = 9'd260;
      3'd4:    ms = 9'd180;
      default: ms = 9'd300;
    endcase
    return ms;
  endfunction

  // digit*255/9
  function automatic logic [7:0] digit_speed(input logic [3:0] d);
    logic [7:0] sp;
    unique case (d)
      4'd0:    sp = 8'd0;
      4'd1:    sp = 8'd28;
      4'd2:    sp = 8'd56;
      4'd3:    sp = 8'd85;
      4'd4:    sp = 8'd113;
      4'd5:    sp = 8'd141;
      4'd6:    sp = 8'd170;
      4'd7:    sp = 8'd198;
      4'd8:    sp = 8'd226;
      default: sp = 8'd255;
    endcase
    return sp;
  endfunction

endpackage

[rtl/vclc_step.sv]
// Next-state and pin logic for one command byte or one main-loop pass.
module vclc_step
  import vclc_pkg::*;
#(
  parameter int MELODY_NOTES = MELODY_NOTES_DEF
) (
  input  state_t      st,
  input  cfg_t        cfg,
  input  logic        operation,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  elapsed_ms,
  output state_t      nx,
  output logic [15:0] buzzer_hz
);

  localparam logic [7:0] CH_U_LO = "u";
  localparam logic [7:0] CH_V_LO = "v";
  localparam logic [7:0] CH_W_LO = "w";
  localparam logic [7:0] CH_X_LO = "x";
  localparam logic [7:0] CH_Z_LO = "z";
  localparam logic [7:0] CH_A_LO = "a";
  localparam logic [7:0] CH_0    = "0";
  localparam logic [7:0] CH_9    = "9";
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam logic [7:0] CMD_F = "F";
  localparam logic [7:0] CMD_B = "B";
  localparam logic [7:0] CMD_L = "L";
  localparam logic [7:0] CMD_R = "R";
  localparam logic [7:0] CMD_G = "G";
  localparam logic [7:0] CMD_H = "H";
  localparam logic [7:0] CMD_I = "I";
  localparam logic [7:0] CMD_J = "J";
  localparam logic [7:0] CMD_U = "U";
  localparam logic [7:0] CMD_V = "V";
  localparam logic [7:0] CMD_X = "X";
  localparam logic [7:0] CMD_Z = "Z";
  localparam logic [7:0] CMD_Y = "Y";
  localparam logic [7:0] CMD_W = "W";
  localparam logic [7:0] CMD_S = "S";
  localparam logic [7:0] CMD_E = "E";

  typedef enum logic [1:0] {DIR_FWD, DIR_BACK, DIR_SPIN_L, DIR_SPIN_R} dir_t;
  typedef enum logic [1:0] {SIDE_NONE, SIDE_LEFT, SIDE_RIGHT} side_t;

  logic [7:0]  upper;
  logic        do_move;
  dir_t        dir;
  side_t       slow;
  side_t       turn;
  logic        rev;
  logic [17:0] red_prod;
  logic [7:0]  red;
  logic [31:0] now;
  logic        ph;
  logic [3:0]  next_idx;
  logic [31:0] tone_age;

  always_comb begin
    nx = st;
    upper = command_byte;
    do_move = 1'b0;
    dir = DIR_FWD;
    slow = SIDE_NONE;
    turn = SIDE_NONE;
    rev = 1'b0;
    now = st.clock_ms;
    ph = 1'b0;
    next_idx = 4'd0;
    // (sp*3)/5 as sp*615 >> 10, exact for 8-bit sp
    red_prod = 18'(st.speed) * 18'd615;
    red = red_prod[17:10];

    if (!operation) begin
      if (command_byte >= CH_A_LO && command_byte <= CH_Z_LO) begin
        upper = command_byte - CASE_OFS;
      end
      if (command_byte == CH_U_LO) begin
        nx.flags[FL_HEAD] = 1'b0;
        nx.pins.head = 1'b0;
      end else if (command_byte == CH_V_LO) begin
        nx.flags[FL_PARK] = 1'b0;
        nx.pins.front = 1'b0;
        nx.pins.rear = 8'd0;
      end else if (command_byte == CH_W_LO) begin
        nx.flags[FL_PMODE] = 1'b0;
        nx.pins.rear = nx.flags[FL_PARK] ? cfg.park_dim : 8'd0;
      end else if (command_byte == CH_X_LO) begin
        nx.flags[FL_HAZARD] = 1'b0;
        nx.pins.lturn = 1'b0;
        nx.pins.rturn = 1'b0;
      end else if (command_byte == CH_Z_LO) begin
        nx.alarm_on = 1'b0;
        nx.tone_freq = 16'd0;
        nx.tone_len = 16'd0;
      end else begin
        unique case (upper)
          CMD_F: begin do_move = 1'b1; dir = DIR_FWD; end
          CMD_B: begin do_move = 1'b1; dir = DIR_BACK; rev = 1'b1; end
          CMD_L: begin do_move = 1'b1; dir = DIR_SPIN_L; turn = SIDE_LEFT; end
          CMD_R: begin do_move = 1'b1; dir = DIR_SPIN_R; turn = SIDE_RIGHT; end
          CMD_G: begin
            do_move = 1'b1; dir = DIR_FWD; slow = SIDE_LEFT; turn = SIDE_LEFT;
          end
          CMD_H: begin
            do_move = 1'b1; dir = DIR_FWD; slow = SIDE_RIGHT; turn = SIDE_RIGHT;
          end
          CMD_I: begin
            do_move = 1'b1; dir = DIR_BACK; slow = SIDE_LEFT; turn = SIDE_LEFT;
            rev = 1'b1;
          end
          CMD_J: begin
            do_move = 1'b1; dir = DIR_BACK; slow = SIDE_RIGHT; turn = SIDE_RIGHT;
            rev = 1'b1;
          end
          CMD_U: begin
            nx.flags[FL_HEAD] = 1'b1;
            nx.pins.head = 1'b1;
          end
          CMD_V: begin
            nx.flags[FL_PARK] = 1'b1;
            nx.pins.front = 1'b1;
            nx.pins.rear = cfg.park_dim;
          end
          CMD_X: nx.flags[FL_HAZARD] = 1'b1;
          CMD_Z: begin
            nx.alarm_on = !st.alarm_on;
            if (st.alarm_on) begin
              nx.tone_freq = 16'd0;
              nx.tone_len = 16'd0;
            end
          end
          CMD_Y: begin
            if (!st.horn_playing) begin
              nx.horn_playing = 1'b1;
              nx.horn_idx = 3'd0;
              nx.horn_start = st.clock_ms;
              nx.tone_freq = note_hz(3'd0);
              nx.tone_len = 16'(note_ms(3'd0));
              nx.tone_start = st.clock_ms;
            end
          end
          CMD_W: begin
            // parking mode is set first, so no brake hold here
            nx.flags[FL_PMODE] = 1'b1;
            nx.pins.ldrv = DRV_OFF;
            nx.pins.rdrv = DRV_OFF;
            nx.pins.lpwm = 8'd0;
            nx.pins.rpwm = 8'd0;
            nx.pins.rear = 8'd255;
            nx.flags[FL_REV] = 1'b0;
            nx.pins.rev = 1'b0;
          end
          CMD_S: begin
            if (!st.flags[FL_PMODE]) begin
              nx.pins.ldrv = DRV_OFF;
              nx.pins.rdrv = DRV_OFF;
              nx.pins.lpwm = 8'd0;
              nx.pins.rpwm = 8'd0;
              nx.flags[FL_BRAKE] = 1'b1;
              nx.brake_start = st.clock_ms;
              nx.pins.rear = 8'd255;
            end
            nx.flags[FL_LEFT] = 1'b0;
            nx.flags[FL_RIGHT] = 1'b0;
            nx.flags[FL_REV] = 1'b0;
            nx.pins.lturn = 1'b0;
            nx.pins.rturn = 1'b0;
            nx.pins.rev = 1'b0;
          end
          CMD_E: begin
            nx.enabled = !st.enabled;
            if (st.enabled) begin
              nx.pins.ldrv = DRV_OFF;
              nx.pins.rdrv = DRV_OFF;
              nx.pins.lpwm = 8'd0;
              nx.pins.rpwm = 8'd0;
              if (!st.flags[FL_PMODE]) begin
                nx.flags[FL_BRAKE] = 1'b1;
                nx.brake_start = st.clock_ms;
                nx.pins.rear = 8'd255;
              end
              nx.flags[FL_REV] = 1'b0;
              nx.pins.rev = 1'b0;
            end
          end
          default: begin
            if (upper >= CH_0 && upper <= CH_9) begin
              nx.speed = digit_speed(4'(upper - CH_0));
            end
          end
        endcase
      end

      if (do_move) begin
        if (st.enabled && !st.flags[FL_PMODE]) begin
          nx.pins.ldrv = (dir == DIR_FWD || dir == DIR_SPIN_R) ? DRV_FWD : DRV_BACK;
          nx.pins.rdrv = (dir == DIR_FWD || dir == DIR_SPIN_L) ? DRV_FWD : DRV_BACK;
          nx.pins.lpwm = (slow == SIDE_LEFT) ? red : st.speed;
          nx.pins.rpwm = (slow == SIDE_RIGHT) ? red : st.speed;
        end
        if (turn == SIDE_LEFT) begin
          nx.flags[FL_LEFT] = 1'b1;
          nx.flags[FL_RIGHT] = 1'b0;
          nx.pins.rturn = 1'b0;
        end else if (turn == SIDE_RIGHT) begin
          nx.flags[FL_LEFT] = 1'b0;
          nx.flags[FL_RIGHT] = 1'b1;
          nx.pins.lturn = 1'b0;
        end
        nx.flags[FL_REV] = rev;
        nx.pins.rev = rev;
      end
    end else begin
      now = st.clock_ms + 32'(elapsed_ms);
      nx.clock_ms = now;

      if (nx.flags[FL_BRAKE] && (now - nx.brake_start) >= 32'(cfg.brake_hold)) begin
        nx.flags[FL_BRAKE] = 1'b0;
        if (!nx.flags[FL_PMODE]) begin
          nx.pins.rear = nx.flags[FL_PARK] ? cfg.park_dim : 8'd0;
        end
      end

      if (nx.flags[FL_HAZARD] || nx.flags[FL_LEFT] || nx.flags[FL_RIGHT]) begin
        if ((now - nx.blink_last) >= 32'(cfg.turn_half)) begin
          nx.blink_last = now;
          nx.turn_phase = !nx.turn_phase;
        end
        ph = nx.turn_phase;
        if (nx.flags[FL_HAZARD]) begin
          nx.pins.lturn = ph;
          nx.pins.rturn = ph;
        end else begin
          nx.pins.lturn = nx.flags[FL_LEFT] & ph;
          nx.pins.rturn = nx.flags[FL_RIGHT] & ph;
        end
      end else begin
        nx.pins.lturn = 1'b0;
        nx.pins.rturn = 1'b0;
      end

      if (nx.alarm_on && !nx.horn_playing) begin
        if ((now - nx.alarm_last) >= 32'(cfg.alarm_blink)) begin
          nx.alarm_last = now;
          nx.alarm_phase = !nx.alarm_phase;
          nx.pins.head = nx.alarm_phase;
          nx.pins.lturn = nx.alarm_phase;
          nx.pins.rturn = nx.alarm_phase;
        end
        if ((now - nx.beep_last) >= 32'(cfg.alarm_beep)) begin
          nx.beep_last = now;
          nx.tone_freq = BEEP_HZ;
          nx.tone_len = BEEP_MS;
          nx.tone_start = now;
        end
      end

      if (nx.horn_playing &&
          (now - nx.horn_start) >= 32'(10'(note_ms(nx.horn_idx)) + NOTE_GAP_MS)) begin
        next_idx = 4'(nx.horn_idx) + 4'd1;
        if (next_idx >= 4'(MELODY_NOTES)) begin
          nx.horn_playing = 1'b0;
          nx.tone_freq = 16'd0;
          nx.tone_len = 16'd0;
        end else begin
          nx.horn_idx = next_idx[2:0];
          nx.horn_start = now;
          nx.tone_freq = note_hz(next_idx[2:0]);
          nx.tone_len = 16'(note_ms(next_idx[2:0]));
          nx.tone_start = now;
        end
      end
    end
  end

  assign tone_age = nx.clock_ms - nx.tone_start;
  assign buzzer_hz = (tone_age < 32'(nx.tone_len)) ? nx.tone_freq : 16'd0;

endmodule

[rtl/vehicle_command_and_lamp_controller.sv]
// Drive, lamp, alarm and horn controller: one request in, one pin report out per cycle
// while in_stall is low. Each input request is a command byte or a main-loop pass that
// advances the 32-bit millisecond clock by elapsed_ms and then runs brake hold,
// turn/hazard blink, alarm and horn steps. The whole update is combinational logic from
// the input port into the state registers and the output register, so a request's pin
// report appears in the cycle after acceptance; in_stall is raised only while a report
// waits on a stalled output. Configuration writes take effect at the next request.
module vehicle_command_and_lamp_controller
  import vclc_pkg::*;
#(
  parameter int MELODY_NOTES = MELODY_NOTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [7:0]            in_command_byte,
  input  logic [7:0]            in_elapsed_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_left_drive,
  output logic [1:0]            out_right_drive,
  output logic [7:0]            out_left_pwm,
  output logic [7:0]            out_right_pwm,
  output logic                  out_head_lamp,
  output logic                  out_front_park_lamp,
  output logic [7:0]            out_rear_lamp_level,
  output logic                  out_left_turn_lamp,
  output logic                  out_right_turn_lamp,
  output logic                  out_reverse_lamp,
  output logic [15:0]           out_buzzer_hz,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  state_t      st_r;
  state_t      st_nxt;
  state_t      st_rst;
  logic [15:0] buzzer_nxt;
  pins_t       pins_out_r;
  logic [15:0] buzzer_r;
  logic        out_valid_r;
  logic        accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept = in_valid && !in_stall;

  always_comb begin
    st_rst = '0;
    st_rst.speed = SPEED_RST;
    st_rst.enabled = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_hold  <= BRAKE_HOLD_RST;
      cfg_r.turn_half   <= TURN_HALF_RST;
      cfg_r.alarm_blink <= ALARM_BLINK_RST;
      cfg_r.alarm_beep  <= ALARM_BEEP_RST;
      cfg_r.park_dim    <= PARK_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRAKE_HOLD:  cfg_r.brake_hold  <= cfg_wdata;
        REG_TURN_HALF:   cfg_r.turn_half   <= cfg_wdata;
        REG_ALARM_BLINK: cfg_r.alarm_blink <= cfg_wdata;
        REG_ALARM_BEEP:  cfg_r.alarm_beep  <= cfg_wdata;
        REG_PARK_DIM:    cfg_r.park_dim    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  vclc_step #(
    .MELODY_NOTES(MELODY_NOTES)
  ) u_step (
    .st           (st_r),
    .cfg          (cfg_r),
    .operation    (in_operation),
    .command_byte (in_command_byte),
    .elapsed_ms   (in_elapsed_ms),
    .nx           (st_nxt),
    .buzzer_hz    (buzzer_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pins_out_r <= st_nxt.pins;
      buzzer_r <= buzzer_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_drive      = pins_out_r.ldrv;
  assign out_right_drive     = pins_out_r.rdrv;
  assign out_left_pwm        = pins_out_r.lpwm;
  assign out_right_pwm       = pins_out_r.rpwm;
  assign out_head_lamp       = pins_out_r.head;
  assign out_front_park_lamp = pins_out_r.front;
  assign out_rear_lamp_level = pins_out_r.rear;
  assign out_left_turn_lamp  = pins_out_r.lturn;
  assign out_right_turn_lamp = pins_out_r.rturn;
  assign out_reverse_lamp    = pins_out_r.rev;
  assign out_buzzer_hz       = buzzer_r;

  a_accept_reports: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no report");

  a_no_bad_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pins_out_r.ldrv != 2'd3 && pins_out_r.rdrv != 2'd3))
    else $error("illegal motor direction code");

  a_horn_index: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.horn_playing |-> (32'(st_r.horn_idx) < 32'(MELODY_NOTES)))
    else $error("horn note index past melody");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(st_r))
    else $error("state changed without a request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("report valid after reset");

endmodule
